### sv/accel_magnitude_fir_threshold_core_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the magnitude FIR threshold core
// Shared concurrent-assertion wrappers, clocked on clk, reset by rst_n.
// ----------------------------------------------------------------------------
`ifndef ACCEL_MAGNITUDE_FIR_THRESHOLD_CORE_DEFINES_SVH
`define ACCEL_MAGNITUDE_FIR_THRESHOLD_CORE_DEFINES_SVH

// same-cycle implication
`define AMFT_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("amft: same-cycle check failed");

// next-cycle implication
`define AMFT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("amft: next-cycle check failed");

`endif

### sv/amft_pkg.sv
// ----------------------------------------------------------------------------
// amft_pkg
// Types, constants and coefficient lookup for the magnitude FIR threshold core.
// ----------------------------------------------------------------------------
package amft_pkg;

  typedef logic [8:0]  mag_t;
  typedef logic [19:0] coef_t;
  typedef logic [18:0] level_t;

  // magnitude unit result
  typedef struct packed {
    logic done;
    mag_t mag;
  } mag_res_t;

  localparam int       HALF_COEFS   = 23;
  localparam int       PROD_W       = 29;      // coef x magnitude
  localparam int       ACC_W        = 35;      // enough for up to 64 taps
  localparam int       LVL_W        = ACC_W + 10;
  localparam int       Q_FRAC       = 24;
  localparam int       MAG_SCALE    = 61;      // 0.000061 = 61 / 1e6
  localparam int       ROOT_DEN     = 1000000;
  localparam int       LEVEL_GAIN   = 1000;
  localparam level_t   LEVEL_MAX    = 19'h7FFFF;
  localparam level_t   THRESH_RESET = 19'd124500;

  // half of the symmetric low-pass, round(c * 2^24)
  localparam coef_t HALF_COEF [HALF_COEFS] = '{
    20'd4370,   20'd7855,   20'd14438,  20'd24130,  20'd37663,  20'd55749,
    20'd79037,  20'd108041, 20'd143084, 20'd184247, 20'd231321, 20'd283772,
    20'd340737, 20'd401023, 20'd463141, 20'd525353, 20'd585758, 20'd642366,
    20'd693205, 20'd736424, 20'd770400, 20'd793822, 20'd805769
  };

  function automatic coef_t coef_at(input int i, input int taps);
    int k;
    k = taps - 1 - i;
    if (i < k) k = i;
    if (k < 0 || k >= HALF_COEFS) return '0;
    return HALF_COEF[k];
  endfunction

endpackage

### sv/amft_if.sv
// ----------------------------------------------------------------------------
// amft_if
// Valid/ready channels of the core: sample in, result out, threshold write.
// ----------------------------------------------------------------------------
interface amft_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] accel_x;
  logic signed [15:0] accel_y;
  logic signed [15:0] accel_z;
  modport source (output valid, accel_x, accel_y, accel_z, input ready);
  modport sink   (input valid, accel_x, accel_y, accel_z, output ready);
endinterface

interface amft_out_if;
  logic        valid;
  logic        ready;
  logic [18:0] filtered_level;
  logic        detected;
  modport source (output valid, filtered_level, detected, input ready);
  modport sink   (input valid, filtered_level, detected, output ready);
endinterface

interface amft_cfg_if;
  logic        valid;
  logic        ready;
  logic [18:0] data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

### sv/amft_tap_cell.sv
// ----------------------------------------------------------------------------
// amft_tap_cell
// One delay-line cell: holds a magnitude, loads its neighbor's on enable.
// ----------------------------------------------------------------------------
module amft_tap_cell
  import amft_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic en,
  input  mag_t d,
  output mag_t q
);

  mag_t val_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      val_r <= '0;
    end else if (en) begin
      val_r <= d;
    end
  end

  assign q = val_r;

endmodule

### sv/amft_tap_row.sv
// ----------------------------------------------------------------------------
// amft_tap_row
// Row of TAPS cells; each shift moves every entry one cell toward the tail.
// ----------------------------------------------------------------------------
module amft_tap_row
  import amft_pkg::*;
#(
  parameter int TAPS = 46
) (
  input  logic clk,
  input  logic rst_n,
  input  logic shift_en,
  input  mag_t head_in,
  output mag_t tail
);

  mag_t link [TAPS+1];

  assign link[0] = head_in;

  for (genvar i = 0; i < TAPS; i++) begin : g_cell
    amft_tap_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (shift_en),
      .d     (link[i]),
      .q     (link[i+1])
    );
  end

  assign tail = link[TAPS];

endmodule

### sv/amft_mag_unit.sv
// ----------------------------------------------------------------------------
// amft_mag_unit
// floor(sqrt(sumsq * 61 / 1e6)): serial sum of squares, then a restoring root
// search that settles one bit per pass through M_TRY and M_CMP.
// ----------------------------------------------------------------------------
module amft_mag_unit
  import amft_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [15:0] accel_x,
  input  logic signed [15:0] accel_y,
  input  logic signed [15:0] accel_z,
  output mag_res_t           res
);

  typedef enum logic [4:0] {
    M_IDLE  = 5'b00001,
    M_SUMSQ = 5'b00010,
    M_SCALE = 5'b00100,
    M_TRY   = 5'b01000,
    M_CMP   = 5'b10000
  } mstate_t;

  mstate_t     state_r, state_nxt;
  logic [16:0] ax_r, ay_r, az_r;
  logic [1:0]  cnt_r;
  logic [31:0] sum_r;
  logic [37:0] tgt_r;
  logic [17:0] sq_r;
  logic [3:0]  bit_r;
  mag_t        m_r;
  logic        done_r;

  logic [16:0] sel;
  logic [33:0] sel_sq;
  mag_t        trial;
  logic [37:0] trial_scaled;

  function automatic logic [16:0] abs16(input logic signed [15:0] v);
    if (v[15]) return 17'h10000 - {1'b0, v};
    return {1'b0, v};
  endfunction

  always_comb begin
    unique case (cnt_r)
      2'd0:    sel = ax_r;
      2'd1:    sel = ay_r;
      default: sel = az_r;
    endcase
  end

  assign sel_sq       = sel * sel;
  assign trial        = m_r | mag_t'(9'd1 << bit_r);
  assign trial_scaled = 38'(sq_r) * 38'(ROOT_DEN);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      M_IDLE:  if (start) state_nxt = M_SUMSQ;
      M_SUMSQ: if (cnt_r == 2'd2) state_nxt = M_SCALE;
      M_SCALE: state_nxt = M_TRY;
      M_TRY:   state_nxt = M_CMP;
      M_CMP:   state_nxt = (bit_r == 4'd0) ? M_IDLE : M_TRY;
      default: state_nxt = M_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= M_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= (state_r == M_CMP) && (bit_r == 4'd0);
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      M_IDLE: begin
        if (start) begin
          ax_r  <= abs16(accel_x);
          ay_r  <= abs16(accel_y);
          az_r  <= abs16(accel_z);
          cnt_r <= 2'd0;
          sum_r <= '0;
        end
      end
      M_SUMSQ: begin
        sum_r <= sum_r + sel_sq[31:0];
        cnt_r <= cnt_r + 2'd1;
      end
      M_SCALE: begin
        tgt_r <= 38'(sum_r) * 38'(MAG_SCALE);
        m_r   <= '0;
        bit_r <= 4'd8;
      end
      M_TRY: begin
        sq_r <= 18'(trial) * 18'(trial);
      end
      M_CMP: begin
        if (trial_scaled <= tgt_r) m_r <= trial;
        if (bit_r != 4'd0) bit_r <= bit_r - 4'd1;
      end
      default: ;
    endcase
  end

  assign res.done = done_r;
  assign res.mag  = m_r;

endmodule

### sv/accel_magnitude_fir_threshold_core.sv
// A new sample is taken only in S_IDLE, so the serial magnitude unit and the
//   serial MAC walk over the tap row finish before the next sample enters.
// Reset (rst_n, sync, active low): tap row cleared to zero, threshold back to
//   124500, FSMs idle, output channel empty.
// ----------------------------------------------------------------------------
// accel_magnitude_fir_threshold_core
// Accelerometer magnitude, symmetric low-pass FIR and threshold detector.
// ----------------------------------------------------------------------------
`include "accel_magnitude_fir_threshold_core_defines.svh"

module accel_magnitude_fir_threshold_core
  import amft_pkg::*;
#(
  parameter int TAPS = 46
) (
  input  logic       clk,
  input  logic       rst_n,
  amft_in_if.sink    in_ch,
  amft_out_if.source out_ch,
  amft_cfg_if.sink   cfg_ch
);

  localparam int IDX_W = $clog2(TAPS + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TAPS);

  // Top sequencer: wait for magnitude, shift it in, rotate the row once
  // around through the shared MAC, scale, then hand off to the output reg.
  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_MAG   = 5'b00010,
    S_MAC   = 5'b00100,
    S_SCALE = 5'b01000,
    S_EMIT  = 5'b10000
  } state_t;

  state_t             state_r, state_nxt;
  level_t             thresh_r;
  logic [IDX_W-1:0]   mac_idx_r;
  logic [PROD_W-1:0]  prod_r;
  logic               pv_r;
  logic [ACC_W-1:0]   acc_r;
  logic [LVL_W-1:0]   lvl_full_r;
  logic               out_valid_r;
  level_t             out_level_r;
  logic               out_det_r;

  mag_res_t           mag_res;
  logic               mag_start;
  logic               shift_en;
  mag_t               head_in;
  mag_t               tail;
  logic               emit_go;
  level_t             level;

  // ---- configuration: threshold register, always writable ----
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thresh_r <= THRESH_RESET;
    end else if (cfg_ch.valid) begin
      thresh_r <= cfg_ch.data;
    end
  end

  // ---- input side ----
  assign in_ch.ready = (state_r == S_IDLE);
  assign mag_start   = in_ch.valid && in_ch.ready;

  amft_mag_unit u_mag (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mag_start),
    .accel_x (in_ch.accel_x),
    .accel_y (in_ch.accel_y),
    .accel_z (in_ch.accel_z),
    .res     (mag_res)
  );

  // ---- tap row ----
  // New magnitude enters at the head once. During the MAC walk the tail
  // wraps back to the head, so after TAPS shifts the row is restored.
  // At walk step j the tail holds tap TAPS-1-j; the taps are symmetric,
  // so coefficient j applies.
  assign shift_en = ((state_r == S_MAG) && mag_res.done) ||
                    ((state_r == S_MAC) && (mac_idx_r != LAST_IDX));
  assign head_in  = (state_r == S_MAG) ? mag_res.mag : tail;

  amft_tap_row #(
    .TAPS (TAPS)
  ) u_row (
    .clk      (clk),
    .rst_n    (rst_n),
    .shift_en (shift_en),
    .head_in  (head_in),
    .tail     (tail)
  );

  // ---- sequencer ----
  assign emit_go = !out_valid_r || out_ch.ready;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (mag_start) state_nxt = S_MAG;
      S_MAG:   if (mag_res.done) state_nxt = S_MAC;
      S_MAC:   if (mac_idx_r == LAST_IDX) state_nxt = S_SCALE;
      S_SCALE: state_nxt = S_EMIT;
      S_EMIT:  if (emit_go) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      pv_r      <= 1'b0;
      mac_idx_r <= '0;
    end else begin
      state_r <= state_nxt;
      if ((state_r == S_MAG) && mag_res.done) begin
        mac_idx_r <= '0;
        pv_r      <= 1'b0;
      end else if (state_r == S_MAC) begin
        pv_r <= (mac_idx_r != LAST_IDX);
        if (mac_idx_r != LAST_IDX) mac_idx_r <= mac_idx_r + IDX_W'(1);
      end else begin
        pv_r <= 1'b0;
      end
    end
  end

  // ---- shared MAC: product registered, accumulated in the cycle after ----
  always_ff @(posedge clk) begin
    if ((state_r == S_MAG) && mag_res.done) begin
      acc_r <= '0;
    end else if (state_r == S_MAC) begin
      if (mac_idx_r != LAST_IDX) begin
        prod_r <= PROD_W'(coef_at(int'(mac_idx_r), TAPS)) * PROD_W'(tail);
      end
      if (pv_r) acc_r <= acc_r + ACC_W'(prod_r);
    end
  end

  // ---- scale by 1000 from Q11.24, then truncate and saturate ----
  always_ff @(posedge clk) begin
    if (state_r == S_SCALE) begin
      lvl_full_r <= LVL_W'(acc_r) * LVL_W'(LEVEL_GAIN);
    end
  end

  always_comb begin
    if (lvl_full_r[LVL_W-1:Q_FRAC+19] != '0) level = LEVEL_MAX;
    else                                      level = lvl_full_r[Q_FRAC+18:Q_FRAC];
  end

  // ---- output register: next sample may start while this one waits ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((state_r == S_EMIT) && emit_go) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == S_EMIT) && emit_go) begin
      out_det_r   <= (level >= thresh_r);
      out_level_r <= (level >= thresh_r) ? level : '0;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.filtered_level = out_level_r;
  assign out_ch.detected       = out_det_r;

  // ---- checks ----
  `AMFT_ASSERT_NOW(a_mag_done_in_mag, mag_res.done, state_r == S_MAG)
  `AMFT_ASSERT_NOW(a_below_is_zero, out_valid_r && !out_det_r, out_level_r == '0)
  `AMFT_ASSERT_NEXT(a_walk_complete, (state_r == S_MAC) && (state_nxt == S_SCALE), !pv_r)

endmodule
